@@ sv/hkvt_pkg.sv @@
package hkvt_pkg;
    localparam int CAPACITY    = 64;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int VALUE_WIDTH = 32;
    localparam int CODE_W      = 64;
    localparam int QDEPTH      = 2;

    typedef enum logic [2:0] {
        CMD_PUT    = 3'd0,
        CMD_GET    = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_COUNT  = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [2:0]             cmd;
        logic [CODE_W-1:0]      code;
        logic [VALUE_WIDTH-1:0] value;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } t_state;
endpackage

@@ sv/hkvt_if.sv @@
interface hkvt_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [7:0]  key_byte;
    logic        key_last;
    logic [31:0] value_in;
    modport source (output valid, cmd, key_byte, key_last, value_in, input ready);
    modport sink   (input valid, cmd, key_byte, key_last, value_in, output ready);
endinterface

interface hkvt_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_out;
    logic        found;
    logic [6:0]  entry_count;
    logic        status;
    modport source (output valid, value_out, found, entry_count, status, input ready);
    modport sink   (input valid, value_out, found, entry_count, status, output ready);
endinterface

@@ sv/hkvt_front.sv @@
module hkvt_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    hkvt_in_if.sink            in_ch,
    output logic               o_job_valid,
    input  logic               i_job_ready,
    output hkvt_pkg::t_job     o_job
);
    import hkvt_pkg::*;

    logic [CODE_W-1:0] r_acc, n_acc, w_ext;
    t_job              r_q [QDEPTH];
    logic [0:0]        r_wp, r_rp;
    logic [1:0]        r_cnt;
    logic              w_push, w_pop, w_acc_in;

    assign w_ext    = {{(CODE_W-8){in_ch.key_byte[7]}}, in_ch.key_byte};
    assign in_ch.ready = (r_cnt != 2'(QDEPTH));
    assign w_acc_in = in_ch.valid && in_ch.ready;
    assign w_push   = w_acc_in && in_ch.key_last;
    assign w_pop    = o_job_valid && i_job_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job    = r_q[r_rp];

    // fold: code*63 = code*64 - code
    always_comb begin
        n_acc = r_acc;
        if (in_ch.key_byte != 8'd0) begin
            n_acc = (r_acc << 6) - r_acc + w_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_acc_in) begin
                r_acc <= in_ch.key_last ? '0 : n_acc;
            end
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{cmd: in_ch.cmd, code: n_acc, value: in_ch.value_in};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'(QDEPTH))
        else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_acc_in && in_ch.key_last) |-> r_acc == '0)
        else $error("accumulator not cleared after last byte");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !w_pop)
        else $error("pop from empty queue");
endmodule

@@ sv/hkvt_back.sv @@
module hkvt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    output logic               o_job_ready,
    input  hkvt_pkg::t_job     i_job,
    hkvt_out_if.source         out_ch
);
    import hkvt_pkg::*;

    logic [CODE_W-1:0]      r_mcode [CAPACITY];
    logic [VALUE_WIDTH-1:0] r_mval  [CAPACITY];
    logic [CAPACITY-1:0]    r_valid;
    logic [CNT_W-1:0]       r_hw;

    t_state           r_st, n_st;
    t_job             r_job;
    logic [CNT_W-1:0] r_i;
    logic [IDX_W-1:0] r_rd_idx;
    logic [CODE_W-1:0]      r_rd_code;
    logic [VALUE_WIDTH-1:0] r_rd_val;
    logic             r_rd_ok;     // registered read data belongs to a slot index below the high-water mark
    logic             r_hit, r_emp_ok;
    logic [IDX_W-1:0] r_hit_idx, r_emp_idx;
    logic [CNT_W-1:0] r_count;
    logic             r_wr_en;
    logic             r_ov;
    logic [31:0]      r_vout;
    logic             r_fnd, r_stat;
    logic [6:0]       r_cnt_out;

    logic w_match, w_scan_end, w_take;

    assign w_take      = i_job_valid && o_job_ready;
    assign o_job_ready = (r_st == ST_IDLE) && !r_ov;
    // count walks every slot up to the mark, so never stop it on a match
    assign w_match     = r_rd_ok && r_valid[r_rd_idx] && (r_rd_code == r_job.code)
                         && (r_job.cmd != CMD_COUNT);
    assign w_scan_end  = (r_i >= r_hw) && !r_rd_ok;

    assign out_ch.valid       = r_ov;
    assign out_ch.value_out   = r_vout;
    assign out_ch.found       = r_fnd;
    assign out_ch.entry_count = r_cnt_out;
    assign out_ch.status      = r_stat;

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE:  if (w_take) n_st = ST_SCAN;
            ST_SCAN:  if ((w_match && !r_hit) || w_scan_end) n_st = ST_WRITE;
            ST_WRITE: n_st = ST_DONE;
            ST_DONE:  n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    // memory read, one slot per cycle
    always_ff @(posedge i_clk) begin
        r_rd_code <= r_mcode[r_i[IDX_W-1:0]];
        r_rd_val  <= r_mval[r_i[IDX_W-1:0]];
        r_rd_idx  <= r_i[IDX_W-1:0];
        if (r_wr_en) begin
            r_mcode[r_hit_idx] <= r_job.code;
            r_mval[r_hit_idx]  <= r_job.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_hw    <= '0;
            r_ov    <= 1'b0;
            r_rd_ok <= 1'b0;
            r_wr_en <= 1'b0;
            r_i     <= '0;
        end else begin
            r_wr_en <= 1'b0;
            if (out_ch.valid && out_ch.ready) begin
                r_ov <= 1'b0;
            end
            case (r_st)
                ST_IDLE: begin
                    r_i     <= '0;
                    r_rd_ok <= 1'b0;
                    r_hit   <= 1'b0;
                    r_emp_ok <= 1'b0;
                    r_count <= '0;
                    if (w_take) r_job <= i_job;
                end
                ST_SCAN: begin
                    r_rd_ok <= (r_i < r_hw) && !(w_match && !r_hit);
                    if (r_i < r_hw) r_i <= r_i + 1'b1;
                    if (r_rd_ok) begin
                        if (r_valid[r_rd_idx]) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_emp_ok  <= 1'b1;
                            r_emp_idx <= r_rd_idx;
                        end
                    end
                    if (w_match && !r_hit) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_rd_idx;
                        r_vout    <= r_rd_val;
                    end
                end
                ST_WRITE: begin
                    r_fnd     <= 1'b0;
                    r_stat    <= 1'b0;
                    r_cnt_out <= '0;
                    r_vout    <= '0;
                    case (r_job.cmd)
                        CMD_PUT: begin
                            if (r_hit) begin
                                r_fnd   <= 1'b1;
                                r_wr_en <= 1'b1;
                            end else if (r_emp_ok) begin
                                r_hit_idx <= r_emp_idx;
                                r_valid[r_emp_idx] <= 1'b1;
                                r_wr_en <= 1'b1;
                            end else if (r_hw < CNT_W'(CAPACITY)) begin
                                r_hit_idx <= r_hw[IDX_W-1:0];
                                r_valid[r_hw[IDX_W-1:0]] <= 1'b1;
                                r_hw    <= r_hw + 1'b1;
                                r_wr_en <= 1'b1;
                            end else begin
                                r_stat <= 1'b1;
                            end
                        end
                        CMD_GET: begin
                            r_fnd <= r_hit;
                            if (r_hit) r_vout <= r_vout;
                        end
                        CMD_REMOVE: begin
                            r_fnd <= r_hit;
                            if (r_hit) begin
                                r_vout <= r_vout;
                                r_valid[r_hit_idx] <= 1'b0;
                            end
                        end
                        CMD_COUNT: r_cnt_out <= 7'(r_count);
                        CMD_CLEAR: begin
                            r_valid <= '0;
                            r_hw    <= '0;
                        end
                        default: ;
                    endcase
                end
                ST_DONE: r_ov <= 1'b1;
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hw <= CNT_W'(CAPACITY))
        else $error("high-water mark beyond capacity");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_DONE) |=> r_ov)
        else $error("result not presented");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !out_ch.ready) |=> $stable(r_vout) && r_ov)
        else $error("stalled result changed");
endmodule

@@ sv/hashed_key_value_table_unit.sv @@
// Hashed key/value table.
// Input channel: one key byte per word with cmd, key_last and value_in.
// Bytes fold into a 64-bit code (code*63 + signed byte, zero byte skipped).
// On key_last the command (put/get/remove/count/clear) is queued to the
// table engine; non-last bytes give no result.
// Output channel: one result word per command.
// The engine scans the slot memory one slot per cycle up to the high-water
// mark. Get, remove and put-update stop at the first match.
// A two-entry queue lets key bytes keep flowing while a scan runs.
// When the receiver stalls, the result holds and the engine waits; the
// queue then fills and input ready drops.
// Reset (synchronous, active low) empties the table at once through its
// valid flags and high-water mark; no clearing pass is needed.
module hashed_key_value_table_unit (
    input  logic     i_clk,
    input  logic     i_rst_n,
    hkvt_in_if.sink  in_ch,
    hkvt_out_if.source out_ch
);
    import hkvt_pkg::*;

    logic job_valid, job_ready;
    t_job job;

    hkvt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_job_valid(job_valid), .i_job_ready(job_ready), .o_job(job)
    );

    hkvt_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(job_valid), .o_job_ready(job_ready), .i_job(job),
        .out_ch(out_ch)
    );
endmodule
